[rtl/nlzh_pkg.sv]
// Shared types and constants for the NTC linearize / zone PID heater block.
// No dependencies; used by the divider and the top level of the block.
package nlzh_pkg;

  localparam int DVD_W = 26;
  localparam int DSR_W = 13;

  localparam logic [2:0] CFG_GAIN_P   = 3'd0;
  localparam logic [2:0] CFG_GAIN_I   = 3'd1;
  localparam logic [2:0] CFG_GAIN_D   = 3'd2;
  localparam logic [2:0] CFG_INT_LIM  = 3'd3;
  localparam logic [2:0] CFG_TGT_CAP  = 3'd4;

  localparam logic [11:0] VREF_MV      = 12'd3600;
  localparam logic [11:0] FULL_SCALE   = 12'd4095;
  localparam logic [13:0] DIVIDER_OHMS = 14'd10000;
  localparam logic [11:0] DEFAULT_TEMP = 12'd2500;
  localparam logic [11:0] TEMP_MAX     = 12'd3750;
  localparam logic [7:0]  DEG_STEP     = 8'd250;
  localparam logic [6:0]  PCT_DIV      = 7'd100;
  localparam logic [6:0]  DUTY_MAX     = 7'd100;
  localparam logic [13:0] DUTY_SAT_SUM = 14'd10100;
  localparam logic [10:0] NS_PER_PCT   = 11'd2000;

  localparam logic [14:0] OHM_TBL [16] = '{
    15'd32650, 15'd25390, 15'd19900, 15'd15710, 15'd12490, 15'd10000, 15'd8057, 15'd6531,
    15'd5327,  15'd4369,  15'd3603,  15'd2986,  15'd2488,  15'd2083,  15'd1752, 15'd1481
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_VGO, ST_VW, ST_RGO, ST_RW, ST_IGO, ST_IW,
    ST_PIDE, ST_PIDA, ST_MP, ST_MI, ST_MD, ST_MS, ST_DUTY, ST_DGO, ST_DW, ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/nlzh_div.sv]
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on nlzh_pkg (request/response structs).
module nlzh_div (
  input  logic              clk,
  input  logic              rst_n,
  input  nlzh_pkg::div_req_t req,
  output nlzh_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(nlzh_pkg::DVD_W + 1);

  logic [nlzh_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [nlzh_pkg::DSR_W-1:0] dsr_r;
  logic [nlzh_pkg::DSR_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic                       done_r;
  logic [nlzh_pkg::DSR_W:0]   trial;
  logic                       qbit;

  always_comb begin
    trial   = {rem_r, dvd_r[nlzh_pkg::DVD_W-1]};
    qbit    = (trial >= {1'b0, dsr_r});
    rem_nxt = qbit ? nlzh_pkg::DSR_W'(trial - {1'b0, dsr_r})
                   : nlzh_pkg::DSR_W'(trial);
    dvd_nxt = {dvd_r[nlzh_pkg::DVD_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (req.start) begin
      cnt_r  <= CNT_W'(nlzh_pkg::DVD_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (cnt_r != '0) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

[rtl/ntc_linearize_zone_pid_heater.sv]
// Top level: sequencer, thermistor linearization and per-zone PID datapath.
// Depends on nlzh_pkg and nlzh_div.
//
// Usage: one input beat on in_* carries a zone's converter sample, target and
// fault flag (in_tuser). One output beat on out_* carries the zone, the
// linearized temperature, duty and PWM pulse width; out_tuser is temp_valid.
// in_tready is high only while the sequencer is idle; one item at a time.
// A conversion fault goes straight to the output; a zero or negative sample,
// or one outside the voltage window, skips the linearization and runs the PID
// on the default temperature; a table end skips the interpolation division,
// and a saturated duty skips the final division. The next item is accepted in
// the cycle after the result is loaded. The single shared divider (one
// quotient bit per cycle) runs up to four times per item: volts, ohms,
// interpolation and the final duty scaling; the P, I and D products go
// through one shared 11x18 multiplier in turn.
// The result sits in an output register; the next item is taken while it
// waits, and the sequencer stalls at its last step if the receiver has not
// taken the previous beat. Reset (rst_n low, synchronous) loads the register
// defaults, clears every zone's integrator and last error, and empties the
// output register.
module ntc_linearize_zone_pid_heater #(
  parameter int ZONES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // zone[1:0], raw_sample[14:2], target_c[22:15]
  input  logic        in_tuser,   // adc_fault
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_zone[1:0], temp_x100[13:2], duty[20:14], pulse_ns[38:21]
  output logic        out_tuser,  // temp_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;

  nlzh_pkg::state_t   state_r, state_nxt;
  nlzh_pkg::div_req_t div_req;
  nlzh_pkg::div_rsp_t div_rsp;

  logic [9:0]  kp_r, ki_r, kd_r;
  logic [15:0] lim_r;
  logic [7:0]  cap_r;

  logic [1:0]         zone_r;
  logic signed [12:0] raw_r;
  logic               fault_r;
  logic [7:0]         target_r;
  logic [25:0]        r_r;
  logic [3:0]         seg_r;
  logic [11:0]        temp_r;
  logic               valid_r;
  logic [6:0]         duty_r;
  logic signed [15:0] err_r;
  logic signed [17:0] acc_r;
  logic signed [16:0] deriv_r;
  logic signed [28:0] prod_r;
  logic signed [31:0] sum_r;

  logic signed [17:0] integ_r [ZONES];
  logic signed [15:0] last_r  [ZONES];

  logic               out_tvalid_r;
  logic [39:0]        out_tdata_r;
  logic               out_tuser_r;

  logic               in_acc;
  logic [ZW-1:0]      zidx;
  logic               zone_in;
  logic [11:0]        vq;
  logic [3:0]         seg_c;
  logic               r_hi, r_lo;
  logic [14:0]        ohm_k, ohm_k1;
  logic [12:0]        off_c, span_c;
  logic [7:0]         sp_deg;
  logic signed [15:0] sp_c;
  logic signed [18:0] acc_sum;
  logic signed [18:0] lim_s;
  logic signed [17:0] acc_c;
  logic [9:0]         mul_a;
  logic signed [17:0] mul_b;
  logic               out_free;

  assign in_acc   = in_tvalid && in_tready;
  assign zidx     = ZW'(zone_r);
  assign zone_in  = (32'(zone_r) < ZONES);
  assign vq       = div_rsp.quotient[11:0];
  assign out_free = !out_tvalid_r || out_tready;

  // Segment search over the descending ohm table.
  always_comb begin
    seg_c = '0;
    for (int k = 0; k < 15; k++) begin
      if (r_r <= 26'(nlzh_pkg::OHM_TBL[k]) && r_r > 26'(nlzh_pkg::OHM_TBL[k+1]))
        seg_c = 4'(k);
    end
    r_hi   = (r_r >= 26'(nlzh_pkg::OHM_TBL[0]));
    r_lo   = (r_r <= 26'(nlzh_pkg::OHM_TBL[15]));
    ohm_k  = nlzh_pkg::OHM_TBL[seg_c];
    ohm_k1 = nlzh_pkg::OHM_TBL[4'(seg_c + 4'd1)];
    off_c  = 13'(ohm_k - r_r[14:0]);
    span_c = 13'(ohm_k - ohm_k1);
  end

  always_comb begin
    sp_deg  = (target_r < cap_r) ? target_r : cap_r;
    sp_c    = 16'(sp_deg * 7'd100);
    lim_s   = 19'(signed'({1'b0, lim_r}));
    acc_sum = 19'(integ_r[zidx]) + 19'(err_r);
    if (acc_sum > lim_s)       acc_c = 18'(lim_s);
    else if (acc_sum < -lim_s) acc_c = 18'(-lim_s);
    else                       acc_c = 18'(acc_sum);
  end

  always_comb begin
    case (state_r)
      nlzh_pkg::ST_MP: begin mul_a = kp_r; mul_b = 18'(err_r);   end
      nlzh_pkg::ST_MI: begin mul_a = ki_r; mul_b = acc_r;        end
      default:         begin mul_a = kd_r; mul_b = 18'(deriv_r); end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nlzh_pkg::ST_IDLE: if (in_acc) state_nxt = nlzh_pkg::ST_CHK;
      nlzh_pkg::ST_CHK: begin
        if (fault_r)                          state_nxt = nlzh_pkg::ST_FIN;
        else if (raw_r[12] || raw_r == '0)    state_nxt = nlzh_pkg::ST_PIDE;
        else                                  state_nxt = nlzh_pkg::ST_VGO;
      end
      nlzh_pkg::ST_VGO: state_nxt = nlzh_pkg::ST_VW;
      nlzh_pkg::ST_VW: begin
        if (div_rsp.done)
          state_nxt = (vq == '0 || vq >= nlzh_pkg::VREF_MV) ? nlzh_pkg::ST_PIDE
                                                            : nlzh_pkg::ST_RGO;
      end
      nlzh_pkg::ST_RGO: state_nxt = nlzh_pkg::ST_RW;
      nlzh_pkg::ST_RW:  if (div_rsp.done) state_nxt = nlzh_pkg::ST_IGO;
      nlzh_pkg::ST_IGO: state_nxt = (r_hi || r_lo) ? nlzh_pkg::ST_PIDE : nlzh_pkg::ST_IW;
      nlzh_pkg::ST_IW:  if (div_rsp.done) state_nxt = nlzh_pkg::ST_PIDE;
      nlzh_pkg::ST_PIDE: state_nxt = zone_in ? nlzh_pkg::ST_PIDA : nlzh_pkg::ST_FIN;
      nlzh_pkg::ST_PIDA: state_nxt = nlzh_pkg::ST_MP;
      nlzh_pkg::ST_MP:   state_nxt = nlzh_pkg::ST_MI;
      nlzh_pkg::ST_MI:   state_nxt = nlzh_pkg::ST_MD;
      nlzh_pkg::ST_MD:   state_nxt = nlzh_pkg::ST_MS;
      nlzh_pkg::ST_MS:   state_nxt = nlzh_pkg::ST_DUTY;
      nlzh_pkg::ST_DUTY: begin
        if (sum_r < 0 || sum_r >= 32'(nlzh_pkg::DUTY_SAT_SUM)) state_nxt = nlzh_pkg::ST_FIN;
        else                                                  state_nxt = nlzh_pkg::ST_DGO;
      end
      nlzh_pkg::ST_DGO: state_nxt = nlzh_pkg::ST_DW;
      nlzh_pkg::ST_DW:  if (div_rsp.done) state_nxt = nlzh_pkg::ST_FIN;
      nlzh_pkg::ST_FIN: if (out_free) state_nxt = nlzh_pkg::ST_IDLE;
      default: state_nxt = nlzh_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_tready        = (state_r == nlzh_pkg::ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_r)
      nlzh_pkg::ST_VGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 26'(raw_r[11:0] * nlzh_pkg::VREF_MV);
        div_req.divisor  = 13'(nlzh_pkg::FULL_SCALE);
      end
      nlzh_pkg::ST_RGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = 26'(r_r[11:0] * nlzh_pkg::DIVIDER_OHMS);
        div_req.divisor  = 13'(nlzh_pkg::VREF_MV - r_r[11:0]);
      end
      nlzh_pkg::ST_IGO: begin
        div_req.start    = !(r_hi || r_lo);
        div_req.dividend = 26'(off_c * nlzh_pkg::DEG_STEP);
        div_req.divisor  = span_c;
      end
      nlzh_pkg::ST_DGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = sum_r[25:0];
        div_req.divisor  = 13'(nlzh_pkg::PCT_DIV);
      end
      default: ;
    endcase
  end

  nlzh_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= nlzh_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= 10'd120;
      ki_r  <= 10'd10;
      kd_r  <= 10'd5;
      lim_r <= 16'd10000;
      cap_r <= 8'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        nlzh_pkg::CFG_GAIN_P:  kp_r  <= cfg_wdata[9:0];
        nlzh_pkg::CFG_GAIN_I:  ki_r  <= cfg_wdata[9:0];
        nlzh_pkg::CFG_GAIN_D:  kd_r  <= cfg_wdata[9:0];
        nlzh_pkg::CFG_INT_LIM: lim_r <= cfg_wdata;
        nlzh_pkg::CFG_TGT_CAP: cap_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Zone state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int z = 0; z < ZONES; z++) begin
        integ_r[z] <= '0;
        last_r[z]  <= '0;
      end
    end else if (state_r == nlzh_pkg::ST_PIDA) begin
      integ_r[zidx] <= acc_c;
      last_r[zidx]  <= err_r;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      nlzh_pkg::ST_IDLE: if (in_acc) begin
        zone_r   <= in_tdata[1:0];
        raw_r    <= in_tdata[14:2];
        target_r <= in_tdata[22:15];
        fault_r  <= in_tuser;
      end
      nlzh_pkg::ST_CHK: begin
        valid_r <= !fault_r;
        temp_r  <= fault_r ? 12'd0 : nlzh_pkg::DEFAULT_TEMP;
        duty_r  <= '0;
      end
      nlzh_pkg::ST_VW: if (div_rsp.done) r_r <= 26'(vq);   // holds v until ohms are known
      nlzh_pkg::ST_RW: if (div_rsp.done) r_r <= div_rsp.quotient;
      nlzh_pkg::ST_IGO: begin
        seg_r <= seg_c;
        if (r_hi)      temp_r <= '0;
        else if (r_lo) temp_r <= nlzh_pkg::TEMP_MAX;
      end
      nlzh_pkg::ST_IW: if (div_rsp.done)
        temp_r <= 12'(seg_r * nlzh_pkg::DEG_STEP) + 12'(div_rsp.quotient[7:0]);
      nlzh_pkg::ST_PIDE: err_r <= sp_c - signed'({4'b0, temp_r});
      nlzh_pkg::ST_PIDA: begin
        acc_r   <= acc_c;
        deriv_r <= 17'(err_r) - 17'(last_r[zidx]);
      end
      nlzh_pkg::ST_MP: prod_r <= signed'({1'b0, mul_a}) * mul_b;
      nlzh_pkg::ST_MI: begin
        prod_r <= signed'({1'b0, mul_a}) * mul_b;
        sum_r  <= 32'(prod_r);
      end
      nlzh_pkg::ST_MD: begin
        prod_r <= signed'({1'b0, mul_a}) * mul_b;
        sum_r  <= sum_r + 32'(prod_r);
      end
      nlzh_pkg::ST_MS: sum_r <= sum_r + 32'(prod_r);
      nlzh_pkg::ST_DUTY: begin
        if (sum_r < 0) duty_r <= '0;
        else           duty_r <= nlzh_pkg::DUTY_MAX;
      end
      nlzh_pkg::ST_DW: if (div_rsp.done) duty_r <= div_rsp.quotient[6:0];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == nlzh_pkg::ST_FIN && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == nlzh_pkg::ST_FIN && out_free) begin
      out_tdata_r <= {1'b0, 18'(duty_r * nlzh_pkg::NS_PER_PCT), duty_r, temp_r, zone_r};
      out_tuser_r <= valid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[rtl/nlzh_checker.sv]
// Port-level checks for the heater block, bound to the top level.
// Depends only on the top level's ports.
module nlzh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[38:2] == 37'd0)
    else $error("fault beat carries nonzero temp or duty");

  a_duty_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:14] <= 7'd100 &&
                   out_tdata[38:21] == 18'(out_tdata[20:14] * 18'd2000))
    else $error("duty out of range or pulse width mismatch");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind ntc_linearize_zone_pid_heater nlzh_checker u_nlzh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
